// File: hw/rtl/smwi_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// smwi_pkg: shared types and constants for the suffix match / insert block
// Holds the channel word types, the sequencer states, register indexes and
// default sizes.
// ---------------------------------------------------------------------------
package smwi_pkg;

    localparam int          DEF_MAX_SUFFIX = 8;
    localparam int          DEF_MAX_INSERT = 8;
    localparam int          LEN_W          = 4;
    localparam int          CFG_DATA_W     = 64;
    localparam int          CFG_IDX_W      = 3;
    localparam logic [7:0]  SEPARATOR      = 8'd32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SUFFIX_LEN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUFFIX_CHARS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INSERT_LEN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INSERT_CHARS = 3'd3;

    typedef struct packed {
        logic [7:0] ch;
        logic       is_final;
    } smwi_in_t;

    typedef struct packed {
        logic [7:0] out_ch;
        logic       out_valid;
        logic       out_last;
    } smwi_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_CHAR,
        ST_INS,
        ST_SEP,
        ST_MARK
    } smwi_state_t;

endpackage

// File: hw/rtl/suffix_match_word_insert.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// suffix_match_word_insert: word suffix match with insert word
// Streams text bytes through, and after every word that ends with the
// configured suffix emits the configured insert word.
// ---------------------------------------------------------------------------
// Takes one text byte per input word (is_final marks the end of the text) and
// returns result words: each byte that is not a space passes straight on; at a
// space or at the final byte the ended word is checked against the suffix by
// one shared byte comparator, one suffix byte per cycle, and on a match the
// insert word follows, one byte per cycle while the result register is free.
// A space is passed on unless it is the final byte (with suffix_len 0
// everything passes unchanged). A final byte that yields no byte returns one
// empty result with out_valid 0 and out_last 1. Each byte is accepted, then
// its first result is loaded; a space, a dropped final space and an empty end
// marker take the place of the byte's own result. At a word end the compare
// covers min(suffix_len, MAX_SUFFIX) suffix bytes if suffix_len is nonzero,
// then insert bytes on a match; a result load waits while a result is held.
// in_ready is low while the sequencer works on a byte; the result
// register lets the next byte be taken while the last result still waits.
// Configuration writes are taken at any time (cfg_ready stays high) but must
// only be issued while the block is idle.
// ---------------------------------------------------------------------------
module suffix_match_word_insert #(
    parameter int MAX_SUFFIX = smwi_pkg::DEF_MAX_SUFFIX,
    parameter int MAX_INSERT = smwi_pkg::DEF_MAX_INSERT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // text bytes
    input  logic                                in_valid,
    output logic                                in_ready,
    input  smwi_pkg::smwi_in_t                  in_word,
    // results
    output logic                                res_valid,
    input  logic                                res_ready,
    output smwi_pkg::smwi_out_t                 res_word,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [smwi_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [smwi_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import smwi_pkg::*;

    localparam int SUF_W = MAX_SUFFIX * 8;
    localparam int INS_W = MAX_INSERT * 8;
    localparam int SIW   = (MAX_SUFFIX > 1) ? $clog2(MAX_SUFFIX) : 1;
    localparam int IIW   = (MAX_INSERT > 1) ? $clog2(MAX_INSERT) : 1;
    localparam logic [LEN_W-1:0] MAX_SUF_L = LEN_W'(MAX_SUFFIX);
    localparam logic [LEN_W-1:0] MAX_INS_L = LEN_W'(MAX_INSERT);

    // configuration registers
    logic [LEN_W-1:0] suffix_len_reg;
    logic [SUF_W-1:0] suffix_chars_reg;
    logic [LEN_W-1:0] insert_len_reg;
    logic [INS_W-1:0] insert_chars_reg;

    // word state
    logic [7:0]       recent_reg [MAX_SUFFIX];
    logic [LEN_W-1:0] word_length_reg;

    // sequencer
    smwi_state_t      state_reg, state_next;
    logic [7:0]       ch_reg;
    logic             final_reg;
    logic             match_reg, match_next;
    logic [LEN_W-1:0] cnt_reg, cnt_next;
    logic [LEN_W-1:0] ins_cnt_reg, ins_cnt_next;

    // result register
    logic             res_valid_reg, res_valid_next;
    smwi_out_t        res_word_reg, res_word_next;

    logic [LEN_W-1:0] suf_eff;
    logic [LEN_W-1:0] ins_eff;
    logic             in_accept;
    logic             in_sep;
    logic             need_cmp;
    logic             is_sep;
    logic             emit_space;
    logic             ins_pending;
    logic             slot_free;
    logic             load;
    logic             do_shift;
    logic             do_end_word;
    logic             do_clear;
    logic [SIW-1:0]   cmp_idx;
    logic [IIW-1:0]   ins_idx;
    logic             byte_eq;

    // pick the first result of a byte
    function automatic smwi_state_t first_state(input logic has_char, input logic ins,
                                                input logic space, input logic fin);
        smwi_state_t s;
        if (has_char)
            s = ST_CHAR;
        else if (ins)
            s = ST_INS;
        else if (space)
            s = ST_SEP;
        else if (fin)
            s = ST_MARK;
        else
            s = ST_IDLE;
        return s;
    endfunction

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

    // clamp lengths to the storage that exists
    assign suf_eff = (suffix_len_reg > MAX_SUF_L) ? MAX_SUF_L : suffix_len_reg;
    assign ins_eff = (insert_len_reg > MAX_INS_L) ? MAX_INS_L : insert_len_reg;

    assign in_sep   = (in_word.ch == SEPARATOR);
    assign need_cmp = (in_sep || in_word.is_final) && (suf_eff != '0);

    assign is_sep      = (ch_reg == SEPARATOR);
    assign emit_space  = is_sep && (!final_reg || (suf_eff == '0));
    assign ins_pending = match_reg && (ins_eff != '0);

    assign cmp_idx = cnt_reg[SIW-1:0];
    assign ins_idx = ins_cnt_reg[IIW-1:0];
    assign byte_eq = (recent_reg[cmp_idx] == suffix_chars_reg[8*cmp_idx +: 8]);

    assign slot_free = !res_valid_reg || res_ready;

    // ---------------------------------------------------------------------
    // Configuration
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            suffix_len_reg   <= '0;
            suffix_chars_reg <= '0;
            insert_len_reg   <= '0;
            insert_chars_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SUFFIX_LEN:   suffix_len_reg   <= cfg_data[LEN_W-1:0];
                CFG_SUFFIX_CHARS: suffix_chars_reg <= cfg_data[SUF_W-1:0];
                CFG_INSERT_LEN:   insert_len_reg   <= cfg_data[LEN_W-1:0];
                CFG_INSERT_CHARS: insert_chars_reg <= cfg_data[INS_W-1:0];
                default:          ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Sequencer: compare loop, then result emission
    // ---------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        match_next     = match_reg;
        cnt_next       = cnt_reg;
        ins_cnt_next   = ins_cnt_reg;
        load           = 1'b0;
        res_word_next  = res_word_reg;
        do_shift       = 1'b0;
        do_end_word    = 1'b0;
        do_clear       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    do_shift     = !in_sep;
                    match_next   = 1'b1;
                    cnt_next     = '0;
                    ins_cnt_next = '0;
                    if (need_cmp)
                    begin
                        state_next = ST_CMP;
                    end
                    else
                    begin
                        // no compare: close the word right away
                        match_next  = 1'b0;
                        do_end_word = in_sep || in_word.is_final;
                        do_clear    = in_word.is_final;
                        state_next  = first_state(!in_sep, 1'b0,
                                                  in_sep && (!in_word.is_final ||
                                                             (suf_eff == '0)),
                                                  in_word.is_final);
                    end
                end
            end

            ST_CMP:
            begin
                // one suffix byte per cycle through the shared comparator
                match_next = match_reg && byte_eq && (word_length_reg >= suf_eff);
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == suf_eff - 1'b1)
                begin
                    do_end_word = 1'b1;
                    do_clear    = final_reg;
                    state_next  = first_state(!is_sep,
                                              match_next && (ins_eff != '0),
                                              emit_space, final_reg);
                end
            end

            ST_CHAR:
            begin
                if (slot_free)
                begin
                    load = 1'b1;
                    if (ins_pending)
                        state_next = ST_INS;
                    else if (emit_space)
                        state_next = ST_SEP;
                    else
                        state_next = ST_IDLE;
                    res_word_next = '{out_ch: ch_reg, out_valid: 1'b1,
                                      out_last: final_reg && (state_next == ST_IDLE)};
                end
            end

            ST_INS:
            begin
                if (slot_free)
                begin
                    load         = 1'b1;
                    ins_cnt_next = ins_cnt_reg + 1'b1;
                    if (ins_cnt_reg != ins_eff - 1'b1)
                        state_next = ST_INS;
                    else if (emit_space)
                        state_next = ST_SEP;
                    else
                        state_next = ST_IDLE;
                    res_word_next = '{out_ch: insert_chars_reg[8*ins_idx +: 8],
                                      out_valid: 1'b1,
                                      out_last: final_reg && (state_next == ST_IDLE)};
                end
            end

            ST_SEP:
            begin
                if (slot_free)
                begin
                    load          = 1'b1;
                    state_next    = ST_IDLE;
                    res_word_next = '{out_ch: SEPARATOR, out_valid: 1'b1,
                                      out_last: final_reg};
                end
            end

            ST_MARK:
            begin
                if (slot_free)
                begin
                    load          = 1'b1;
                    state_next    = ST_IDLE;
                    res_word_next = '{out_ch: 8'd0, out_valid: 1'b0, out_last: 1'b1};
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // hold the result until taken, then drop it
        if (load)
            res_valid_next = 1'b1;
        else if (res_ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
            match_reg     <= 1'b0;
            cnt_reg       <= '0;
            ins_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            match_reg     <= match_next;
            cnt_reg       <= cnt_next;
            ins_cnt_reg   <= ins_cnt_next;
        end
    end

    // captured byte and result payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            ch_reg    <= in_word.ch;
            final_reg <= in_word.is_final;
        end
        res_word_reg <= res_word_next;
    end

    // ---------------------------------------------------------------------
    // Word state: recent bytes (entry 0 newest) and saturating length
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_SUFFIX; i++)
                recent_reg[i] <= '0;
            word_length_reg <= '0;
        end
        else if (do_clear)
        begin
            for (int i = 0; i < MAX_SUFFIX; i++)
                recent_reg[i] <= '0;
            word_length_reg <= '0;
        end
        else if (do_end_word)
        begin
            word_length_reg <= '0;
        end
        else if (do_shift)
        begin
            for (int i = MAX_SUFFIX - 1; i > 0; i--)
                recent_reg[i] <= recent_reg[i-1];
            recent_reg[0] <= in_word.ch;
            if (word_length_reg < MAX_SUF_L)
                word_length_reg <= word_length_reg + 1'b1;
        end
    end

endmodule
